// ----- hdl/memory_card_serial_responder_assert.svh -----
// Assertion helpers used by the card responder RTL.
`ifndef MEMORY_CARD_SERIAL_RESPONDER_ASSERT_SVH
`define MEMORY_CARD_SERIAL_RESPONDER_ASSERT_SVH

// Clocked check, masked while reset is held.
`define MCSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is held.
`define MCSR_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mcsr_pkg.sv -----
`default_nettype none
package mcsr_pkg;

	localparam int SECT_ADDR_W  = 16;
	localparam int SECTOR_BYTES = 128;
	localparam int OFF_W        = 7;

	localparam logic [7:0] BYTE_SELECT = 8'h81;
	localparam logic [7:0] BYTE_READ   = 8'h52;
	localparam logic [7:0] BYTE_WRITE  = 8'h57;
	localparam logic [7:0] BYTE_ID1    = 8'h5A;
	localparam logic [7:0] BYTE_ID2    = 8'h5D;
	localparam logic [7:0] BYTE_ACK1   = 8'h5C;
	localparam logic [7:0] BYTE_ACK2   = 8'h5D;
	localparam logic [7:0] BYTE_END    = 8'h47;
	localparam logic [7:0] BYTE_IDLE   = 8'hFF;
	localparam logic [7:0] STATUS_INIT = 8'h08;

	localparam logic [7:0] STEP_IDLE     = 8'd0;
	localparam logic [7:0] STEP_CMD      = 8'd1;
	localparam logic [7:0] STEP_ID1      = 8'd2;
	localparam logic [7:0] STEP_ID2      = 8'd3;
	localparam logic [7:0] STEP_ADDR_HI  = 8'd4;
	localparam logic [7:0] STEP_ADDR_LO  = 8'd5;
	localparam logic [7:0] STEP_RD_ACK1  = 8'd6;
	localparam logic [7:0] STEP_RD_ACK2  = 8'd7;
	localparam logic [7:0] STEP_RD_AHI   = 8'd8;
	localparam logic [7:0] STEP_RD_ALO   = 8'd9;
	localparam logic [7:0] STEP_RD_FIRST = 8'd10;
	localparam logic [7:0] STEP_RD_LAST  = 8'd137;
	localparam logic [7:0] STEP_RD_CSUM  = 8'd138;
	localparam logic [7:0] STEP_RD_END   = 8'd139;
	localparam logic [7:0] STEP_WR_FIRST = 8'd6;
	localparam logic [7:0] STEP_WR_LAST  = 8'd133;
	localparam logic [7:0] STEP_WR_CSUM  = 8'd134;
	localparam logic [7:0] STEP_WR_ACK1  = 8'd135;
	localparam logic [7:0] STEP_WR_ACK2  = 8'd136;
	localparam logic [7:0] STEP_WR_END   = 8'd137;
	localparam logic [7:0] STEP_MAX      = 8'd255;

	typedef enum logic [1:0] {
		KIND_READ    = 2'd0,
		KIND_WRITE   = 2'd1,
		KIND_ID      = 2'd2,
		KIND_UNKNOWN = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SRC_CONST = 2'd0,
		SRC_MEM   = 2'd1,
		SRC_CSUM  = 2'd2
	} src_t;

	typedef enum logic [1:0] {
		CSUM_HOLD    = 2'd0,
		CSUM_LOAD    = 2'd1,
		CSUM_XOR_TX  = 2'd2,
		CSUM_XOR_MEM = 2'd3
	} csum_op_t;

endpackage
`default_nettype wire

// ----- hdl/memory_card_serial_responder.sv -----
// A reply passes stage 1 and the output register before it shows on m_tvalid.
// Throughput: one request per cycle while m_tready drains replies, except that
// the address LSB byte of a read or write frame is followed by s_tready low while the sector-number
// reduction unit takes the address modulo SECTORS by reciprocal multiplication.
// Reset: all control state resets at once; the card array is then zeroed one byte
// per cycle across all SECTORS*128 bytes, during which s_tready stays low.
`default_nettype none
`include "memory_card_serial_responder_assert.svh"
module memory_card_serial_responder #(
	parameter int SECTORS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [0] cs_level, [8:1] tx_byte, [15:9] zero
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [7:0] rx_byte, [8] ack, [15:9] zero
);
	import mcsr_pkg::*;

	localparam int SW    = $clog2(SECTORS);
	localparam int AW    = SW + OFF_W;
	localparam int DEPTH = SECTORS * SECTOR_BYTES;

	logic       acc;
	logic       op;
	logic       lvl;
	logic [7:0] tx;

	logic       cs_q, fsel_q;
	logic [7:0] step_q;
	kind_t      kind_q;
	logic [15:0] addr_q;
	logic [7:0] prev_q, stat_q, csum_q;

	logic       cs_d, fsel_d;
	logic [7:0] step_d, step_inc;
	kind_t      kind_d;
	logic [15:0] addr_d;
	logic [7:0] prev_d, stat_d;

	logic [7:0] r_c;
	logic       ack_c, mem_wr_c, mod_start_c;
	src_t       src_c;
	csum_op_t   cop_c;

	logic       mod_busy;
	logic [SW-1:0] sec_idx;

	logic       clearing_q;
	logic [AW-1:0] clr_q;

	logic [7:0] mem [DEPTH];
	logic       mem_we;
	logic [AW-1:0] mem_waddr, rd_idx, wr_idx;
	logic [7:0] mem_wdata, mem_rdata_q;

	logic       s1_valid_q;
	logic [7:0] byte_s1, tx_s1;
	logic       ack_s1;
	src_t       src_s1;
	csum_op_t   cop_s1;
	logic       s1_go;
	logic [7:0] rx_fin;

	logic       out_valid_q, out_ack_q;
	logic [7:0] out_rx_q;

	assign op  = s_tuser;
	assign lvl = s_tdata[0];
	assign tx  = s_tdata[8:1];

	assign s1_go    = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !clearing_q && !mod_busy && (!s1_valid_q || s1_go);
	assign acc      = s_tvalid && s_tready;

	assign rd_idx = {sec_idx, OFF_W'(step_q - STEP_RD_FIRST)};
	assign wr_idx = {sec_idx, OFF_W'(step_q - STEP_WR_FIRST)};

	// protocol decode: everything but the checksum and memory data settles here
	always_comb begin
		cs_d        = cs_q;
		fsel_d      = fsel_q;
		step_d      = step_q;
		kind_d      = kind_q;
		addr_d      = addr_q;
		prev_d      = prev_q;
		stat_d      = stat_q;
		r_c         = BYTE_IDLE;
		ack_c       = 1'b0;
		src_c       = SRC_CONST;
		cop_c       = CSUM_HOLD;
		mem_wr_c    = 1'b0;
		mod_start_c = 1'b0;
		step_inc    = (step_q == STEP_MAX) ? step_q : step_q + 8'd1;
		if (!op) begin
			if (lvl != cs_q) begin
				cs_d   = lvl;
				fsel_d = 1'b0;
				step_d = STEP_IDLE;
			end
		end else if (cs_q) begin
			if (step_q == STEP_IDLE && tx == BYTE_SELECT) begin
				fsel_d = 1'b1;
				step_d = STEP_CMD;
				ack_c  = 1'b1;
			end else begin
				step_d = step_inc;
				if (fsel_q) begin
					if (step_q == STEP_CMD) begin
						r_c = stat_q;
						if (tx == BYTE_READ) begin
							kind_d = KIND_READ;
							ack_c  = 1'b1;
						end else if (tx == BYTE_WRITE) begin
							kind_d = KIND_WRITE;
							ack_c  = 1'b1;
						end else begin
							kind_d = KIND_UNKNOWN;
						end
					end else if (kind_q == KIND_READ) begin
						prev_d = tx;
						ack_c  = 1'b1;
						if (step_q inside {[STEP_RD_FIRST:STEP_RD_LAST]}) begin
							src_c = SRC_MEM;
							cop_c = CSUM_XOR_MEM;
						end else begin
							case (step_q)
								STEP_ID1:     r_c = BYTE_ID1;
								STEP_ID2:     r_c = BYTE_ID2;
								STEP_ADDR_HI: begin
									addr_d = {tx, 8'h00};
									cop_c  = CSUM_LOAD;
									r_c    = 8'h00;
								end
								STEP_ADDR_LO: begin
									addr_d      = {addr_q[15:8], tx};
									cop_c       = CSUM_XOR_TX;
									r_c         = prev_q;
									mod_start_c = 1'b1;
								end
								STEP_RD_ACK1: r_c = BYTE_ACK1;
								STEP_RD_ACK2: r_c = BYTE_ACK2;
								STEP_RD_AHI:  r_c = addr_q[15:8];
								STEP_RD_ALO:  r_c = addr_q[7:0];
								STEP_RD_CSUM: src_c = SRC_CSUM;
								STEP_RD_END: begin
									r_c   = BYTE_END;
									ack_c = 1'b0;
								end
								default:      r_c = 8'h00;
							endcase
						end
					end else if (kind_q == KIND_WRITE) begin
						prev_d = tx;
						ack_c  = 1'b1;
						stat_d = 8'h00;
						if (step_q inside {[STEP_WR_FIRST:STEP_WR_LAST]}) begin
							mem_wr_c = 1'b1;
							cop_c    = CSUM_XOR_TX;
							r_c      = prev_q;
						end else begin
							case (step_q)
								STEP_ID1:     r_c = BYTE_ID1;
								STEP_ID2:     r_c = BYTE_ID2;
								STEP_ADDR_HI: begin
									addr_d = {tx, 8'h00};
									cop_c  = CSUM_LOAD;
									r_c    = 8'h00;
								end
								STEP_ADDR_LO: begin
									addr_d      = {addr_q[15:8], tx};
									cop_c       = CSUM_XOR_TX;
									r_c         = prev_q;
									mod_start_c = 1'b1;
								end
								STEP_WR_CSUM: r_c = prev_q;
								STEP_WR_ACK1: r_c = BYTE_ACK1;
								STEP_WR_ACK2: r_c = BYTE_ACK2;
								STEP_WR_END: begin
									r_c   = BYTE_END;
									ack_c = 1'b0;
								end
								default:      r_c = 8'h00;
							endcase
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q   <= 1'b0;
			fsel_q <= 1'b0;
			step_q <= STEP_IDLE;
			kind_q <= KIND_READ;
			addr_q <= '0;
			prev_q <= '0;
			stat_q <= STATUS_INIT;
		end else if (acc) begin
			cs_q   <= cs_d;
			fsel_q <= fsel_d;
			step_q <= step_d;
			kind_q <= kind_d;
			addr_q <= addr_d;
			prev_q <= prev_d;
			stat_q <= stat_d;
		end
	end

	mcsr_sector_mod #(
		.SECTORS(SECTORS)
	) u_sector_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (acc && mod_start_c),
		.dividend ({addr_q[15:8], tx}),
		.busy     (mod_busy),
		.remainder(sec_idx)
	);

	// zero the card array after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign mem_we    = clearing_q || (acc && mem_wr_c);
	assign mem_waddr = clearing_q ? clr_q : wr_idx;
	assign mem_wdata = clearing_q ? 8'h00 : tx;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (acc) begin
			mem_rdata_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			byte_s1 <= r_c;
			tx_s1   <= tx;
			ack_s1  <= ack_c;
			src_s1  <= src_c;
			cop_s1  <= cop_c;
		end
	end

	always_comb begin
		case (src_s1)
			SRC_CONST: rx_fin = byte_s1;
			SRC_MEM:   rx_fin = mem_rdata_q;
			SRC_CSUM:  rx_fin = csum_q;
			default:   rx_fin = byte_s1;
		endcase
	end

	// checksum updates in request order as each reply moves from stage 1 to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csum_q <= '0;
		end else if (s1_go) begin
			case (cop_s1)
				CSUM_HOLD:    csum_q <= csum_q;
				CSUM_LOAD:    csum_q <= tx_s1;
				CSUM_XOR_TX:  csum_q <= csum_q ^ tx_s1;
				CSUM_XOR_MEM: csum_q <= csum_q ^ mem_rdata_q;
				default:      csum_q <= csum_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_rx_q  <= rx_fin;
			out_ack_q <= ack_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_ack_q, out_rx_q};

	`MCSR_ASSERT(a_clear_blocks_input, clearing_q |-> !s_tready, "request taken while clearing")
	`MCSR_ASSERT(a_s1_holds_on_stall, (s1_valid_q && out_valid_q && !m_tready) |=> s1_valid_q, "stage 1 dropped under stall")
	`MCSR_ASSERT(a_no_write_while_reducing, mod_busy |-> !mem_we, "card write during sector reduction")
	`MCSR_ASSERT(a_clear_covers_array, $fell(clearing_q) |-> ($past(clr_q) == AW'(DEPTH - 1)), "clear pass ended early")
	`MCSR_ASSERT_NR(a_sector_in_range, !mod_busy |-> ({1'b0, sec_idx} < (SW+1)'(SECTORS)), "sector index out of range")

endmodule
`default_nettype wire

// ----- hdl/mcsr_sector_mod.sv -----
`default_nettype none
module mcsr_sector_mod #(
	parameter int SECTORS = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [mcsr_pkg::SECT_ADDR_W-1:0]     dividend,
	output logic                                 busy,
	output logic [$clog2(SECTORS)-1:0]           remainder
);
	import mcsr_pkg::*;

	localparam int SW = $clog2(SECTORS);
	localparam int QW = SECT_ADDR_W + 1;
	localparam int PW = SECT_ADDR_W + QW;
	localparam int SH = SECT_ADDR_W + SW;
	localparam longint RECIP_L =
		((longint'(1) << SH) + longint'(SECTORS) - longint'(1)) / longint'(SECTORS);
	localparam logic [QW-1:0]          RECIP   = QW'(RECIP_L);
	localparam logic [SECT_ADDR_W:0]   DIVISOR = (SECT_ADDR_W+1)'(SECTORS);

	logic                   busy_q;
	logic                   half_q;
	logic [SECT_ADDR_W-1:0] x_q;
	logic [SECT_ADDR_W-1:0] quo_q;
	logic [SW-1:0]          rem_q;
	logic [PW-1:0]          prod;
	logic [SECT_ADDR_W-1:0] quo_d;
	logic [SECT_ADDR_W-1:0] back;
	logic [SW-1:0]          rem_d;

	// reciprocal multiply: the quotient is registered while half_q is low, then the remainder while half_q is high
	always_comb begin
		prod  = PW'(x_q) * PW'(RECIP);
		quo_d = SECT_ADDR_W'(prod >> SH);
		back  = SECT_ADDR_W'(quo_q * DIVISOR);
		rem_d = SW'(x_q - back);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			half_q <= 1'b0;
			x_q    <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			half_q <= 1'b0;
			x_q    <= dividend;
		end else if (busy_q) begin
			if (!half_q) begin
				quo_q  <= quo_d;
				half_q <= 1'b1;
			end else begin
				rem_q  <= rem_d;
				half_q <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire
